// ===== src/i2a_pkg.sv =====
package i2a_pkg;

    localparam int WORD_W    = 32;
    localparam int DIGITS    = 11;
    localparam int DIGIT_W   = 4;
    localparam int CHAR_W    = 7;
    localparam int BIT_CNT_W = $clog2(WORD_W + 1);
    localparam int DIG_CNT_W = $clog2(DIGITS + 1);

    localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'h2D;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;
    localparam logic [CHAR_W-1:0] CHAR_UPPER = 7'h41;

    typedef enum logic [1:0] {
        CMD_SDEC = 2'd0,
        CMD_UDEC = 2'd1,
        CMD_OCT  = 2'd2,
        CMD_HEX  = 2'd3
    } t_cmd;

    typedef struct packed {
        t_cmd              cmd;
        logic [WORD_W-1:0] value;
    } t_in;

    typedef struct packed {
        logic [CHAR_W-1:0] char_code;
        logic              last;
    } t_out;

    // control from the sequencer to the digit register
    typedef struct packed {
        logic clear;
        logic shift_in;
        logic bit_in;
        logic shift_out;
    } t_conv_ctl;

    function automatic logic [DIGIT_W:0] radix_of(input t_cmd cmd);
        logic [DIGIT_W:0] r;
        case (cmd)
            CMD_SDEC: r = 5'd10;
            CMD_UDEC: r = 5'd10;
            CMD_OCT:  r = 5'd8;
            CMD_HEX:  r = 5'd16;
            default:  r = 5'd10;
        endcase
        return r;
    endfunction

    function automatic logic [CHAR_W-1:0] glyph(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] c;
        if (d < 4'd10) begin
            c = CHAR_ZERO + {3'd0, d};
        end else begin
            c = CHAR_UPPER + {3'd0, d - 4'd10};
        end
        return c;
    endfunction

endpackage

// ===== src/integer_to_ascii_radix_top.sv =====
// integer to ascii text converter: each input transfer carries a 32-bit value
// and a format (signed decimal, unsigned decimal, octal, upper-case hex); the
// block answers with one output transfer per character, most significant
// digit first, with last set on the final one. no leading zeros, zero gives
// a single '0', and a negative signed value gives '-' and then its magnitude.
// the value is shifted msb first into an eleven-digit register whose digits
// double-and-correct in the chosen radix, one bit per cycle; the digit
// register is then shifted out one digit a cycle, dropping leading zeros,
// then emitting, where each digit waits for a free output register and a sent
// minus sign. a new input is taken only once the block is back in idle,
// after the last character is loaded. a finished character may wait in the
// output register while the next item is taken.
module integer_to_ascii_radix_top import i2a_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out_data
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_SKIP,
        ST_EMIT
    } t_state;

    t_state                r_state;
    t_cmd                  r_cmd;
    logic [WORD_W-1:0]     r_value;
    logic [BIT_CNT_W-1:0]  r_bits;
    logic [DIG_CNT_W-1:0]  r_left;
    logic                  r_sign_pend;
    logic                  r_out_valid;
    t_out                  r_out_data;

    logic                  w_in_xfer;
    logic                  w_out_free;
    logic                  w_neg;
    logic [DIGIT_W-1:0]    w_top;
    logic                  w_skip;
    logic                  w_emit;
    logic                  w_load;
    t_conv_ctl             w_ctl;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign w_in_xfer   = i_in_valid && o_in_ready;
    // output register is free when empty or being drained this cycle
    assign w_out_free  = !r_out_valid || i_out_ready;
    assign w_neg       = (i_in_data.cmd == CMD_SDEC) && i_in_data.value[WORD_W-1];

    // leading zero: drop it, but always keep the least significant digit
    assign w_skip = (r_state == ST_SKIP) && (w_top == '0) && (r_left > DIG_CNT_W'(1));
    // digits wait behind a pending minus sign
    assign w_emit = (r_state == ST_EMIT) && w_out_free && !r_sign_pend;
    // output register takes a new character this cycle
    assign w_load = (r_sign_pend && w_out_free) || w_emit;

    always_comb begin
        w_ctl.clear     = w_in_xfer;
        w_ctl.shift_in  = (r_state == ST_CONV);
        w_ctl.bit_in    = r_value[WORD_W-1];
        w_ctl.shift_out = w_skip || w_emit;
    end

    i2a_conv u_conv (
        .i_clk       (i_clk),
        .i_ctl       (w_ctl),
        .i_cmd       (r_cmd),
        .o_top_digit (w_top)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_sign_pend <= 1'b0;
            r_out_valid <= 1'b0;
            r_bits      <= '0;
            r_left      <= '0;
        end else begin
            // output register drains on transfer unless refilled
            if (r_out_valid && i_out_ready && !w_load) begin
                r_out_valid <= 1'b0;
            end

            // the minus sign goes out as soon as the output is free,
            // while conversion runs
            if (r_sign_pend && w_out_free) begin
                r_out_valid          <= 1'b1;
                r_out_data.char_code <= CHAR_MINUS;
                r_out_data.last      <= 1'b0;
                r_sign_pend          <= 1'b0;
            end

            case (r_state)
                ST_IDLE: begin
                    if (w_in_xfer) begin
                        r_cmd       <= i_in_data.cmd;
                        // two's complement magnitude for negative signed values
                        r_value     <= w_neg ? (~i_in_data.value + WORD_W'(1))
                                             : i_in_data.value;
                        r_sign_pend <= w_neg;
                        r_bits      <= BIT_CNT_W'(WORD_W);
                        r_state     <= ST_CONV;
                    end
                end
                ST_CONV: begin
                    r_value <= {r_value[WORD_W-2:0], 1'b0};
                    r_bits  <= r_bits - BIT_CNT_W'(1);
                    if (r_bits == BIT_CNT_W'(1)) begin
                        r_left  <= DIG_CNT_W'(DIGITS);
                        r_state <= ST_SKIP;
                    end
                end
                ST_SKIP: begin
                    if (w_skip) begin
                        r_left <= r_left - DIG_CNT_W'(1);
                    end else begin
                        r_state <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    if (w_emit) begin
                        r_out_valid          <= 1'b1;
                        r_out_data.char_code <= glyph(w_top);
                        r_out_data.last      <= (r_left == DIG_CNT_W'(1));
                        r_left               <= r_left - DIG_CNT_W'(1);
                        if (r_left == DIG_CNT_W'(1)) begin
                            r_state <= ST_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

// ===== src/i2a_conv.sv =====
module i2a_conv import i2a_pkg::*; (
    input  logic               i_clk,
    input  t_conv_ctl          i_ctl,
    input  t_cmd               i_cmd,
    output logic [DIGIT_W-1:0] o_top_digit
);

    logic [DIGIT_W-1:0] r_digits [DIGITS];
    logic [DIGIT_W-1:0] n_digits [DIGITS];
    logic [DIGIT_W-1:0] w_next   [DIGITS];
    logic [DIGIT_W:0]   w_sum    [DIGITS];
    logic [DIGITS-1:0]  w_cin;
    logic [DIGITS-1:0]  w_cout;
    logic [DIGIT_W:0]   w_radix;
    logic [DIGIT_W-1:0] w_half;

    assign w_radix = radix_of(i_cmd);
    assign w_half  = w_radix[DIGIT_W:1];

    // each digit doubles and takes the carry from below; the carry out
    // depends only on the digit itself, so all digits update at once
    always_comb begin
        for (int i = 0; i < DIGITS; i++) begin
            w_cout[i] = (r_digits[i] >= w_half);
        end
        w_cin[0] = i_ctl.bit_in;
        for (int i = 1; i < DIGITS; i++) begin
            w_cin[i] = w_cout[i-1];
        end
        for (int i = 0; i < DIGITS; i++) begin
            w_sum[i]  = {r_digits[i], w_cin[i]};
            w_next[i] = DIGIT_W'(w_sum[i] - (w_cout[i] ? w_radix : 5'd0));
        end
    end

    always_comb begin
        for (int i = 0; i < DIGITS; i++) begin
            n_digits[i] = r_digits[i];
        end
        if (i_ctl.clear) begin
            for (int i = 0; i < DIGITS; i++) begin
                n_digits[i] = '0;
            end
        end else if (i_ctl.shift_in) begin
            for (int i = 0; i < DIGITS; i++) begin
                n_digits[i] = w_next[i];
            end
        end else if (i_ctl.shift_out) begin
            n_digits[0] = '0;
            for (int i = 1; i < DIGITS; i++) begin
                n_digits[i] = r_digits[i-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < DIGITS; i++) begin
            r_digits[i] <= n_digits[i];
        end
    end

    assign o_top_digit = r_digits[DIGITS-1];

endmodule

// ===== dv/integer_to_ascii_radix_top_test.sv =====
module integer_to_ascii_radix_top_test;
    import i2a_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // generous bound: ~375 numbers, up to 11 characters each
    // behind a stalling receiver, plus sender gaps and the drain pauses
    localparam int unsigned CYCLE_LIMIT   = 400000;
    localparam int unsigned RESET_CYCLES  = 12;
    localparam int unsigned RANDOM_ITEMS  = 350;
    localparam int unsigned IDLE_PERCENT  = 18;
    localparam int unsigned SETTLE_CYCLES = 60;
    localparam int unsigned REPORT_LIMIT  = 10;

    // predicts the text of each accepted number and checks characters in order
    class text_tracker;
        t_out        pending_chars[$];
        int unsigned mismatches;

        function new();
            mismatches = 0;
        endfunction

        function void note_number(t_in item);
            logic [WORD_W-1:0]  mag;
            logic [WORD_W-1:0]  base;
            logic [DIGIT_W-1:0] digs[DIGITS];
            int                 n;
            t_out               c;
            mag  = item.value;
            base = (item.cmd == CMD_OCT) ? 32'd8 : (item.cmd == CMD_HEX) ? 32'd16 : 32'd10;
            n    = 0;
            if (item.cmd == CMD_SDEC && mag[WORD_W-1]) begin
                c.char_code = CHAR_MINUS;
                c.last      = 1'b0;
                pending_chars.push_back(c);
                mag = 32'd0 - mag;
            end
            do begin
                digs[n] = DIGIT_W'(mag % base);
                mag     = mag / base;
                n++;
            end while (mag != 0 && n < DIGITS);
            for (int k = n - 1; k >= 0; k--) begin
                if (digs[k] < 4'd10) begin
                    c.char_code = CHAR_ZERO + CHAR_W'(digs[k]);
                end else begin
                    c.char_code = CHAR_UPPER + CHAR_W'(digs[k] - 4'd10);
                end
                c.last = (k == 0);
                pending_chars.push_back(c);
            end
        endfunction

        function void check_char(t_out got);
            t_out want;
            if (pending_chars.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT) begin
                    $display("unexpected character: char_code %h last %b",
                             got.char_code, got.last);
                end
                return;
            end
            want = pending_chars.pop_front();
            if (want.char_code !== got.char_code || want.last !== got.last) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT) begin
                    $display("character differs: expected char_code %h last %b, got %h last %b",
                             want.char_code, want.last, got.char_code, got.last);
                end
            end
        endfunction

        function int unsigned outstanding();
            return pending_chars.size();
        endfunction

        function bit clean();
            return mismatches == 0 && pending_chars.size() == 0;
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    logic i_in_valid;
    logic o_in_ready;
    t_in  i_in_data;
    logic o_out_valid;
    logic i_out_ready;
    t_out o_out_data;

    // set while neither side may idle, giving one long back-to-back stretch
    logic        steady;
    int unsigned cycle_count;
    text_tracker tracker;

    integer_to_ascii_radix_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    // 10 ns clock
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // output side: samples the pre-edge values, so a transfer is seen exactly
    // at the edge that completes it; ready drops at random outside the steady
    // stretch
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            tracker.check_char(o_out_data);
        end
        i_out_ready <= steady || ($urandom_range(0, 99) >= IDLE_PERCENT);
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("integer_to_ascii_radix_top: mismatch");
            $finish;
        end
    end

    function automatic t_in number_of(t_cmd cmd, logic [WORD_W-1:0] value);
        t_in item;
        item.cmd   = cmd;
        item.value = value;
        return item;
    endfunction

    // random number, weighted towards the interesting corners of each format
    function automatic t_in random_number();
        t_in               item;
        logic [WORD_W-1:0] pow;
        logic [WORD_W-1:0] base;
        int unsigned       pick;
        int unsigned       kmax;
        item.cmd = t_cmd'($urandom_range(0, 3));
        pick     = $urandom_range(0, 99);
        if (pick < 40) begin
            item.value = $urandom;
        end else if (pick < 55) begin
            item.value = $urandom_range(0, 20);
        end else if (pick < 72) begin
            // exact powers of the radix and one below, where the digit count steps
            base = (item.cmd == CMD_OCT) ? 32'd8 : (item.cmd == CMD_HEX) ? 32'd16 : 32'd10;
            kmax = (item.cmd == CMD_OCT) ? 10 : (item.cmd == CMD_HEX) ? 7 : 9;
            pow  = 32'd1;
            repeat ($urandom_range(0, kmax)) pow = pow * base;
            item.value = pow - $urandom_range(0, 1);
        end else if (pick < 88) begin
            // small negative numbers, mostly printed with a sign
            if ($urandom_range(0, 3) != 0) begin
                item.cmd = CMD_SDEC;
            end
            item.value = 32'd0 - $urandom_range(1, 100000);
        end else begin
            case ($urandom_range(0, 3))
                0:       item.value = 32'h0000_0000;
                1:       item.value = 32'hFFFF_FFFF;
                2:       item.value = 32'h8000_0000;
                default: item.value = 32'h7FFF_FFFF;
            endcase
        end
        return item;
    endfunction

    // one input transfer; called at a rising edge and returns at the edge of
    // acceptance. valid is only dropped when a gap is actually taken, so it
    // never gets two assignments in one step
    task automatic send_number(t_in item);
        int unsigned gap;
        gap = 0;
        if (!steady && $urandom_range(0, 99) < IDLE_PERCENT) begin
            gap = $urandom_range(1, 6);
        end
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= item;
        do @(posedge i_clk); while (!o_in_ready);
        tracker.note_number(item);
    endtask

    // sender holds off until every predicted character has been transferred
    task automatic drain_text();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (tracker.outstanding() != 0);
    endtask

    initial begin
        t_in directed[$];

        tracker     = new();
        cycle_count = 0;
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_in_data   <= '0;
        i_out_ready <= 1'b0;
        steady      <= 1'b0;

        // zero in every format
        directed.push_back(number_of(CMD_SDEC, 32'h0000_0000));
        directed.push_back(number_of(CMD_UDEC, 32'h0000_0000));
        directed.push_back(number_of(CMD_OCT,  32'h0000_0000));
        directed.push_back(number_of(CMD_HEX,  32'h0000_0000));
        // signed: most negative, most positive, minus one, ordinary negative, small positive
        directed.push_back(number_of(CMD_SDEC, 32'h8000_0000));
        directed.push_back(number_of(CMD_SDEC, 32'h7FFF_FFFF));
        directed.push_back(number_of(CMD_SDEC, 32'hFFFF_FFFF));
        directed.push_back(number_of(CMD_SDEC, 32'hFFFF_CFC7));
        directed.push_back(number_of(CMD_SDEC, 32'd9));
        // unsigned: all ones, top bit alone, digit-count steps
        directed.push_back(number_of(CMD_UDEC, 32'hFFFF_FFFF));
        directed.push_back(number_of(CMD_UDEC, 32'h8000_0000));
        directed.push_back(number_of(CMD_UDEC, 32'd10));
        directed.push_back(number_of(CMD_UDEC, 32'd1000000000));
        // octal: eleven digits of all ones, around one digit step
        directed.push_back(number_of(CMD_OCT,  32'hFFFF_FFFF));
        directed.push_back(number_of(CMD_OCT,  32'd7));
        directed.push_back(number_of(CMD_OCT,  32'd8));
        directed.push_back(number_of(CMD_OCT,  32'h4000_0000));
        // hex: every letter, all ones, digit step
        directed.push_back(number_of(CMD_HEX,  32'hFFFF_FFFF));
        directed.push_back(number_of(CMD_HEX,  32'hABCD_EF01));
        directed.push_back(number_of(CMD_HEX,  32'h0000_000F));
        directed.push_back(number_of(CMD_HEX,  32'h0000_0010));
        directed.push_back(number_of(CMD_HEX,  32'h1234_5678));

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed[k]) begin
            send_number(directed[k]);
        end
        drain_text();

        for (int unsigned k = 0; k < RANDOM_ITEMS; k++) begin
            // no idling on either side for a long run of back-to-back numbers
            if (k == 100) begin
                steady <= 1'b1;
            end else if (k == 180) begin
                steady <= 1'b0;
            end
            if (k == 250) begin
                drain_text();
            end
            send_number(random_number());
        end
        i_in_valid <= 1'b0;

        while (tracker.outstanding() != 0) @(posedge i_clk);
        // catch any stray character after the last expected one
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (tracker.clean()) begin
            $display("integer_to_ascii_radix_top: match");
        end else begin
            $display("integer_to_ascii_radix_top: mismatch");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
src/i2a_pkg.sv
src/i2a_conv.sv
src/integer_to_ascii_radix_top.sv
dv/integer_to_ascii_radix_top_test.sv
